// File: rtl/tlq_pkg.sv
`timescale 1ns / 1ps
package tlq_pkg;

    localparam int MAX_IN        = 4;
    localparam int N_IN_DEF      = 4;
    localparam int N_OUT_DEF     = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ITEM_DEPTH    = 2;
    localparam int RES_DEPTH     = 2;
    localparam int WIDE_W        = 80;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_GROW  = 2'd2
    } cmd_t;

    localparam logic [1:0] TGT_CENTER    = 2'd0;
    localparam logic [1:0] TGT_BASE      = 2'd1;
    localparam logic [1:0] TGT_GAIN      = 2'd2;
    localparam logic [1:0] TGT_ELLIPSOID = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEGEN = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic [2:0] CFG_SCALE_INV_0 = 3'd0;
    localparam logic [2:0] CFG_SCALE_INV_1 = 3'd1;
    localparam logic [2:0] CFG_SCALE_INV_2 = 3'd2;
    localparam logic [2:0] CFG_SCALE_INV_3 = 3'd3;

    localparam logic signed [WIDE_W-1:0] SAT_HI = 80'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -80'sd2147483648;

    typedef struct packed {
        cmd_t                        cmd;
        logic [1:0]                  target;
        logic [5:0]                  row;
        logic [5:0]                  col;
        logic signed [31:0]          value;
        logic [MAX_IN-1:0][31:0]     point;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               in_region;
        logic [5:0]         index;
        logic signed [31:0] value;
        logic               last;
    } res_t;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        r.ovf = 1'b0;
        r.val = v[31:0];
        if (v > SAT_HI)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh7fffffff;
        end
        else if (v < SAT_LO)
        begin
            r.ovf = 1'b1;
            r.val = 32'sh80000000;
        end
        return r;
    endfunction

endpackage

// File: rtl/tlq_fifo.sv
`timescale 1ns / 1ps
module tlq_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    input  logic         rd,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr;
    logic          do_rd;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
            if (do_rd)
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + CW'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wdata;
    end

endmodule

// File: rtl/tlq_front.sv
`timescale 1ns / 1ps
module tlq_front import tlq_pkg::*; #(
    parameter int N_IN  = N_IN_DEF,
    parameter int N_OUT = N_OUT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [1:0]  load_target,
    input  logic [5:0]  load_row,
    input  logic [5:0]  load_col,
    input  logic signed [31:0] load_value,
    input  logic signed [31:0] point_0,
    input  logic signed [31:0] point_1,
    input  logic signed [31:0] point_2,
    input  logic signed [31:0] point_3,
    output item_t       item,
    output logic        item_valid,
    input  logic        item_pop
);

    item_t                    item_in;
    logic                     keep;
    logic                     row_in;
    logic                     row_out;
    logic                     col_in;
    logic                     col_out;
    logic                     empty;
    logic [$bits(item_t)-1:0] item_bits;

    assign row_in  = ({1'b0, load_row} < 7'(N_IN));
    assign row_out = ({1'b0, load_row} < 7'(N_OUT));
    assign col_in  = ({1'b0, load_col} < 7'(N_IN));
    assign col_out = ({1'b0, load_col} < 7'(N_OUT));

    // classify: drop unknown commands and loads that hit no entry
    always_comb
    begin
        keep = 1'b0;
        if (command == CMD_QUERY || command == CMD_GROW)
            keep = 1'b1;
        else if (command == CMD_LOAD)
        begin
            unique case (load_target)
                TGT_CENTER:    keep = row_in;
                TGT_BASE:      keep = row_out;
                TGT_GAIN:      keep = row_in && col_out;
                TGT_ELLIPSOID: keep = row_in && col_in;
                default:       keep = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        item_in.cmd      = cmd_t'(command);
        item_in.target   = load_target;
        item_in.row      = load_row;
        item_in.col      = load_col;
        item_in.value    = load_value;
        item_in.point[0] = point_0;
        item_in.point[1] = point_1;
        item_in.point[2] = point_2;
        item_in.point[3] = point_3;
    end

    tlq_fifo #(
        .W     ($bits(item_t)),
        .DEPTH (ITEM_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push && keep),
        .wdata (item_in),
        .rd    (item_pop),
        .rdata (item_bits),
        .full  (full),
        .empty (empty)
    );

    assign item       = item_t'(item_bits);
    assign item_valid = !empty;

endmodule

// File: rtl/tlq_div.sv
`timescale 1ns / 1ps
module tlq_div #(
    parameter int DW = 50
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic signed [31:0]   divisor,
    output logic                 done,
    output logic signed [DW:0]   quotient
);

    localparam int CNT_W = $clog2(DW);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    num_reg;
    logic [31:0]      den_reg;
    logic [31:0]      rem_reg;
    logic             neg_reg;
    logic [32:0]      rem_sh;
    logic             qbit;

    assign rem_sh   = {rem_reg, num_reg[DW-1]};
    assign qbit     = (rem_sh >= {1'b0, den_reg});
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring shift-subtract on magnitudes, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
            den_reg <= divisor[31] ? 32'(-divisor) : 32'(divisor);
            rem_reg <= '0;
            neg_reg <= dividend[DW-1] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            num_reg <= {num_reg[DW-2:0], qbit};
        end
    end

endmodule

// File: rtl/tlq_back.sv
`timescale 1ns / 1ps
module tlq_back import tlq_pkg::*; #(
    parameter int N_IN      = N_IN_DEF,
    parameter int N_OUT     = N_OUT_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  item_t                   item,
    input  logic                    item_valid,
    output logic                    item_pop,
    input  logic [MAX_IN-1:0][30:0] scale_inv,
    output res_t                    res,
    output logic                    res_push,
    input  logic                    res_full
);

    localparam int IW     = (N_IN > 1) ? $clog2(N_IN) : 1;
    localparam int OW     = (N_OUT > 1) ? $clog2(N_OUT) : 1;
    localparam int ED     = N_IN * N_IN;
    localparam int EW     = (ED > 1) ? $clog2(ED) : 1;
    localparam int GD     = N_IN * N_OUT;
    localparam int GW     = (GD > 1) ? $clog2(GD) : 1;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W - FRAC_BITS + 5;
    localparam int DW     = 34 + FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(1) <<< FRAC_BITS;
    localparam logic signed [DW-1:0]    ONE_DW  = DW'(1) <<< FRAC_BITS;
    localparam logic [1:0] SUB_MUL = 2'd1;
    localparam logic [1:0] SUB_USE = 2'd2;

    typedef enum logic [18:0] {
        S_IDLE  = 19'h00001,
        S_DX    = 19'h00002,
        S_QF1   = 19'h00004,
        S_QF2   = 19'h00008,
        S_QBASE = 19'h00010,
        S_QMAC  = 19'h00020,
        S_QEMIT = 19'h00040,
        S_UW1   = 19'h00080,
        S_UW2   = 19'h00100,
        S_UWSAT = 19'h00200,
        S_PACC  = 19'h00400,
        S_PCHK  = 19'h00800,
        S_DIV1S = 19'h01000,
        S_DIV1  = 19'h02000,
        S_DIV2S = 19'h04000,
        S_DIV2  = 19'h08000,
        S_UPD1  = 19'h10000,
        S_UPD2  = 19'h20000,
        S_GEMIT = 19'h40000
    } state_t;

    state_t  state_reg, state_next;
    logic [1:0]    sub_reg, sub_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [OW-1:0] o_reg, o_next;

    item_t              it_reg;
    logic signed [31:0] ctr_reg [N_IN];
    logic signed [31:0] e_reg [ED];
    logic signed [31:0] base_mem [N_OUT];
    logic signed [31:0] gain_mem [GD];
    logic signed [31:0] base_q;
    logic signed [31:0] gain_q;
    logic signed [31:0] dx_reg [N_IN];
    logic signed [31:0] u_reg [N_IN];
    logic signed [31:0] w_reg [N_IN];
    logic signed [ACC_W-1:0] u_acc [N_IN];
    logic signed [ACC_W-1:0] w_acc [N_IN];
    logic signed [31:0] t_reg, m_reg, p_reg, c1_reg, c_reg;
    logic signed [ACC_W-1:0] q_acc, acc_reg, p_acc;
    logic               flag_reg, zero_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_sh;
    sat_t                     prod_sat, acc_sat, p_sat, q_sat, upd_sat;
    sat_t                     u_sat [N_IN];
    sat_t                     w_sat [N_IN];
    logic                     uw_ovf;
    logic signed [31:0]       e_cur;
    logic [EW-1:0]            ei;
    logic [GW-1:0]            ga_rd;
    logic                     use_now, i_last, j_last, o_last, ij_last;
    logic                     ld_now;
    logic                     div_start, div_done;
    logic signed [DW-1:0]     div_num;
    logic signed [DW:0]       div_q;

    assign use_now = (sub_reg == SUB_USE);
    assign i_last  = (i_reg == IW'(N_IN - 1));
    assign j_last  = (j_reg == IW'(N_IN - 1));
    assign o_last  = (o_reg == OW'(N_OUT - 1));
    assign ij_last = i_last && j_last;
    assign ei      = EW'(EW'(i_reg) * EW'(N_IN) + EW'(j_reg));
    assign ga_rd   = GW'(GW'(j_reg) * GW'(N_OUT) + GW'(o_reg));
    assign e_cur   = e_reg[ei];
    assign ld_now  = (state_reg == S_IDLE) && item_valid && (item.cmd == CMD_LOAD);

    assign prod_sh  = prod_reg >>> FRAC_BITS;
    assign prod_sat = sat32(WIDE_W'(prod_sh));
    assign acc_sat  = sat32(WIDE_W'(acc_reg));
    assign p_sat    = sat32(WIDE_W'(p_acc));
    assign q_sat    = sat32(WIDE_W'(div_q));
    assign upd_sat  = sat32(WIDE_W'(e_cur) + WIDE_W'(prod_sh));

    always_comb
    begin
        uw_ovf = 1'b0;
        for (int k = 0; k < N_IN; k++)
        begin
            u_sat[k] = sat32(WIDE_W'(u_acc[k]));
            w_sat[k] = sat32(WIDE_W'(w_acc[k]));
            uw_ovf   = uw_ovf | u_sat[k].ovf | w_sat[k].ovf;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DX:
            begin
                mul_a = MUL_W'(signed'(it_reg.point[i_reg])) - MUL_W'(ctr_reg[i_reg]);
                mul_b = signed'({2'b00, scale_inv[i_reg]});
            end
            S_QF1:
            begin
                mul_a = MUL_W'(dx_reg[i_reg]);
                mul_b = MUL_W'(dx_reg[j_reg]);
            end
            S_QF2:
            begin
                mul_a = MUL_W'(t_reg);
                mul_b = MUL_W'(e_cur);
            end
            S_QMAC:
            begin
                mul_a = MUL_W'(signed'(it_reg.point[j_reg])) - MUL_W'(ctr_reg[j_reg]);
                mul_b = MUL_W'(gain_q);
            end
            S_UW1:
            begin
                mul_a = MUL_W'(e_cur);
                mul_b = MUL_W'(dx_reg[j_reg]);
            end
            S_UW2:
            begin
                mul_a = MUL_W'(e_cur);
                mul_b = MUL_W'(dx_reg[i_reg]);
            end
            S_PACC:
            begin
                mul_a = MUL_W'(dx_reg[i_reg]);
                mul_b = MUL_W'(u_reg[i_reg]);
            end
            S_UPD1:
            begin
                mul_a = MUL_W'(u_reg[i_reg]);
                mul_b = MUL_W'(w_reg[j_reg]);
            end
            S_UPD2:
            begin
                mul_a = MUL_W'(c_reg);
                mul_b = MUL_W'(m_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sub_next   = '0;
        i_next     = i_reg;
        j_next     = j_reg;
        o_next     = o_reg;
        item_pop   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_pop = item_valid;
                if (item_valid && (item.cmd == CMD_QUERY || item.cmd == CMD_GROW))
                begin
                    state_next = S_DX;
                    i_next     = '0;
                end
            end
            S_DX:
            begin
                sub_next = sub_reg + 2'd1;
                if (use_now)
                begin
                    sub_next = '0;
                    if (i_last)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = (it_reg.cmd == CMD_QUERY) ? S_QF1 : S_UW1;
                    end
                    else
                        i_next = i_reg + IW'(1);
                end
            end
            S_QF1, S_UW1, S_UPD1:
            begin
                sub_next = sub_reg + 2'd1;
                if (use_now)
                begin
                    sub_next = '0;
                    unique case (state_reg)
                        S_QF1:   state_next = S_QF2;
                        S_UW1:   state_next = S_UW2;
                        default: state_next = S_UPD2;
                    endcase
                end
            end
            S_QF2, S_UW2, S_UPD2:
            begin
                sub_next = sub_reg + 2'd1;
                if (use_now)
                begin
                    sub_next = '0;
                    if (j_last)
                    begin
                        j_next = '0;
                        i_next = i_reg + IW'(1);
                    end
                    else
                        j_next = j_reg + IW'(1);
                    unique case (state_reg)
                        S_QF2:
                        begin
                            state_next = ij_last ? S_QBASE : S_QF1;
                            if (ij_last)
                            begin
                                o_next = '0;
                                j_next = '0;
                            end
                        end
                        S_UW2:   state_next = ij_last ? S_UWSAT : S_UW1;
                        default: state_next = ij_last ? S_GEMIT : S_UPD1;
                    endcase
                end
            end
            S_QBASE:
            begin
                sub_next = sub_reg + 2'd1;
                if (sub_reg == SUB_MUL)
                begin
                    sub_next   = '0;
                    j_next     = '0;
                    state_next = S_QMAC;
                end
            end
            S_QMAC:
            begin
                sub_next = sub_reg + 2'd1;
                if (use_now)
                begin
                    sub_next = '0;
                    if (j_last)
                        state_next = S_QEMIT;
                    else
                        j_next = j_reg + IW'(1);
                end
            end
            S_QEMIT:
            begin
                if (!res_full)
                begin
                    if (o_last)
                        state_next = S_IDLE;
                    else
                    begin
                        o_next     = o_reg + OW'(1);
                        state_next = S_QBASE;
                    end
                end
            end
            S_UWSAT:
            begin
                i_next     = '0;
                state_next = S_PACC;
            end
            S_PACC:
            begin
                sub_next = sub_reg + 2'd1;
                if (use_now)
                begin
                    sub_next = '0;
                    if (i_last)
                        state_next = S_PCHK;
                    else
                        i_next = i_reg + IW'(1);
                end
            end
            S_PCHK:  state_next = (p_sat.val == 32'sd0) ? S_GEMIT : S_DIV1S;
            S_DIV1S: state_next = S_DIV1;
            S_DIV1:  state_next = div_done ? S_DIV2S : S_DIV1;
            S_DIV2S: state_next = S_DIV2;
            S_DIV2:
            begin
                if (div_done)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_UPD1;
                end
            end
            S_GEMIT:
            begin
                if (!res_full)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sub_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            o_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            o_reg     <= o_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (ld_now && item.target == TGT_CENTER)
            ctr_reg[item.row[IW-1:0]] <= item.value;
        if (ld_now && item.target == TGT_ELLIPSOID)
            e_reg[EW'(EW'(item.row) * EW'(N_IN) + EW'(item.col))] <= item.value;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    it_reg   <= item;
                    flag_reg <= 1'b0;
                    zero_reg <= 1'b0;
                    q_acc    <= '0;
                    p_acc    <= '0;
                    for (int k = 0; k < N_IN; k++)
                    begin
                        u_acc[k] <= '0;
                        w_acc[k] <= '0;
                    end
                end
            end
            S_DX:
            begin
                if (use_now)
                begin
                    dx_reg[i_reg] <= prod_sat.val;
                    flag_reg      <= flag_reg | prod_sat.ovf;
                end
            end
            S_QF1:
            begin
                if (use_now)
                begin
                    t_reg    <= prod_sat.val;
                    flag_reg <= flag_reg | prod_sat.ovf;
                end
            end
            S_QF2:
            begin
                if (use_now)
                    q_acc <= q_acc + ACC_W'(prod_sh);
            end
            S_QBASE:
            begin
                if (sub_reg == SUB_MUL)
                    acc_reg <= ACC_W'(base_q);
            end
            S_QMAC:
            begin
                if (use_now)
                    acc_reg <= acc_reg + ACC_W'(prod_sh);
            end
            S_UW1:
            begin
                if (use_now)
                    u_acc[i_reg] <= u_acc[i_reg] + ACC_W'(prod_sh);
            end
            S_UW2:
            begin
                if (use_now)
                    w_acc[j_reg] <= w_acc[j_reg] + ACC_W'(prod_sh);
            end
            S_UWSAT:
            begin
                for (int k = 0; k < N_IN; k++)
                begin
                    u_reg[k] <= u_sat[k].val;
                    w_reg[k] <= w_sat[k].val;
                end
                flag_reg <= flag_reg | uw_ovf;
            end
            S_PACC:
            begin
                if (use_now)
                    p_acc <= p_acc + ACC_W'(prod_sh);
            end
            S_PCHK:
            begin
                p_reg    <= p_sat.val;
                zero_reg <= (p_sat.val == 32'sd0);
                flag_reg <= flag_reg | p_sat.ovf;
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    c1_reg   <= q_sat.val;
                    flag_reg <= flag_reg | q_sat.ovf;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    c_reg    <= q_sat.val;
                    flag_reg <= flag_reg | q_sat.ovf;
                end
            end
            S_UPD1:
            begin
                if (use_now)
                begin
                    m_reg    <= prod_sat.val;
                    flag_reg <= flag_reg | prod_sat.ovf;
                end
            end
            S_UPD2:
            begin
                if (use_now)
                begin
                    e_reg[ei] <= upd_sat.val;
                    flag_reg  <= flag_reg | upd_sat.ovf;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld_now && item.target == TGT_BASE)
            base_mem[item.row[OW-1:0]] <= item.value;
        if (ld_now && item.target == TGT_GAIN)
            gain_mem[GW'(GW'(item.row) * GW'(N_OUT) + GW'(item.col))] <= item.value;
        base_q <= base_mem[o_reg];
        gain_q <= gain_mem[ga_rd];
    end

    assign div_start = (state_reg == S_DIV1S) || (state_reg == S_DIV2S);
    assign div_num   = (state_reg == S_DIV1S) ?
                       ((ONE_DW - DW'(p_reg)) <<< FRAC_BITS) :
                       (DW'(c1_reg) <<< FRAC_BITS);

    tlq_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (p_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign res_push = ((state_reg == S_QEMIT) || (state_reg == S_GEMIT)) && !res_full;

    always_comb
    begin
        if (state_reg == S_QEMIT)
        begin
            res.status    = (flag_reg || acc_sat.ovf) ? ST_SAT : ST_OK;
            res.in_region = (q_acc <= ONE_ACC);
            res.index     = 6'(o_reg);
            res.value     = acc_sat.val;
            res.last      = o_last;
        end
        else
        begin
            res.status    = zero_reg ? ST_DEGEN : (flag_reg ? ST_SAT : ST_OK);
            res.in_region = 1'b0;
            res.index     = '0;
            res.value     = '0;
            res.last      = 1'b1;
        end
    end

endmodule

// File: rtl/tabulation_leaf_query_grow_core.sv
`timescale 1ns / 1ps
// Tabulation leaf with an ellipsoid of accuracy, signed fixed point.
// Input channel (push/full): one request per item. command selects load,
// query or grow; load requests write one center, base, gain or ellipsoid
// entry and produce no result. Unknown commands are dropped.
// Result channel (empty/pop): a query yields N_OUT results, index 0 first,
// the last one flagged; a grow yields one status result.
// Config channel (cfg_valid/cfg_ready): writes the four reciprocal scale
// registers; write only while the block is idle. cfg_ready is always high.
// Timing: the front queue accepts a request every cycle until it fills.
// The back end runs one request at a time on a single 33x33 multiplier,
// and the two divides of a grow run one after the other.
// A stalled result channel holds the back end once the result queue fills.
// Reset empties both queues and returns the scale registers to 1.0;
// table entries are undefined until loaded.
module tabulation_leaf_query_grow_core import tlq_pkg::*; #(
    parameter int N_IN      = N_IN_DEF,
    parameter int N_OUT     = N_OUT_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         command,
    input  logic [1:0]         load_target,
    input  logic [5:0]         load_row,
    input  logic [5:0]         load_col,
    input  logic signed [31:0] load_value,
    input  logic signed [31:0] point_0,
    input  logic signed [31:0] point_1,
    input  logic signed [31:0] point_2,
    input  logic signed [31:0] point_3,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         status,
    output logic               in_region,
    output logic [5:0]         out_index,
    output logic signed [31:0] out_value,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    logic [MAX_IN-1:0][30:0] scale_reg;
    item_t                   item;
    logic                    item_valid;
    logic                    item_pop;
    res_t                    res_in;
    res_t                    res_out;
    logic                    res_push;
    logic                    res_full;
    logic [$bits(res_t)-1:0] res_bits;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_IN; k++)
                scale_reg[k] <= 31'(1 << FRAC_BITS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCALE_INV_0: scale_reg[0] <= cfg_data;
                CFG_SCALE_INV_1: scale_reg[1] <= cfg_data;
                CFG_SCALE_INV_2: scale_reg[2] <= cfg_data;
                CFG_SCALE_INV_3: scale_reg[3] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tlq_front #(
        .N_IN  (N_IN),
        .N_OUT (N_OUT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .load_target (load_target),
        .load_row    (load_row),
        .load_col    (load_col),
        .load_value  (load_value),
        .point_0     (point_0),
        .point_1     (point_1),
        .point_2     (point_2),
        .point_3     (point_3),
        .item        (item),
        .item_valid  (item_valid),
        .item_pop    (item_pop)
    );

    tlq_back #(
        .N_IN      (N_IN),
        .N_OUT     (N_OUT),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .scale_inv  (scale_reg),
        .res        (res_in),
        .res_push   (res_push),
        .res_full   (res_full)
    );

    tlq_fifo #(
        .W     ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .wdata (res_in),
        .rd    (pop),
        .rdata (res_bits),
        .full  (res_full),
        .empty (empty)
    );

    assign res_out   = res_t'(res_bits);
    assign status    = res_out.status;
    assign in_region = res_out.in_region;
    assign out_index = res_out.index;
    assign out_value = res_out.value;
    assign last      = res_out.last;

endmodule

// File: tb/tb_tabulation_leaf_query_grow_core.sv
`timescale 1ns / 1ps
module tb_tabulation_leaf_query_grow_core;
    import tlq_pkg::*;

    localparam int FB = 16;
    localparam int NI = 4;
    localparam int NO = 8;
    localparam logic [1:0] CMD_RSVD = 2'd3;
    localparam longint ONE = 64'sd65536;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        item_t it;
        bit    typed;
        res_t  want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [1:0] command = 2'd0;
    logic [1:0] load_target = 2'd0;
    logic [5:0] load_row = 6'd0;
    logic [5:0] load_col = 6'd0;
    logic signed [31:0] load_value = 32'sd0;
    logic signed [31:0] point_0 = 32'sd0;
    logic signed [31:0] point_1 = 32'sd0;
    logic signed [31:0] point_2 = 32'sd0;
    logic signed [31:0] point_3 = 32'sd0;
    logic empty;
    logic pop = 1'b0;
    logic [1:0] status;
    logic in_region;
    logic [5:0] out_index;
    logic signed [31:0] out_value;
    logic last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = 3'd0;
    logic [30:0] cfg_data = 31'd0;

    // predictor copy of the leaf
    longint leaf_scale [NI];
    longint leaf_center [NI];
    longint leaf_base [NO];
    longint leaf_gain [NI][NO];
    longint leaf_ell [NI][NI];

    res_t leaf_results_q [$];
    int tx_idle = 0;
    int rx_idle = 0;
    int mismatches = 0;
    int n_items = 0;
    int n_results = 0;
    int n_query = 0;
    int n_grow = 0;
    int n_degen = 0;
    int n_sat = 0;
    dir_row_t dir_rows [$];

    tabulation_leaf_query_grow_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .load_target(load_target),
        .load_row   (load_row),
        .load_col   (load_col),
        .load_value (load_value),
        .point_0    (point_0),
        .point_1    (point_1),
        .point_2    (point_2),
        .point_3    (point_3),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .in_region  (in_region),
        .out_index  (out_index),
        .out_value  (out_value),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint fl(input longint v);
        return v >>> FB;
    endfunction

    function automatic longint narrow(input longint v, inout bit f);
        if (v > 64'sd2147483647)
        begin
            f = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            f = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic item_t mk(input logic [1:0] cmd, input logic [1:0] tgt,
                                 input logic [5:0] r, input logic [5:0] c,
                                 input logic [31:0] v, input logic [31:0] p0,
                                 input logic [31:0] p1, input logic [31:0] p2,
                                 input logic [31:0] p3);
        item_t it;
        it.cmd = cmd_t'(cmd);
        it.target = tgt;
        it.row = r;
        it.col = c;
        it.value = v;
        it.point[0] = p0;
        it.point[1] = p1;
        it.point[2] = p2;
        it.point[3] = p3;
        return it;
    endfunction

    // apply one accepted request to the leaf copy and queue its results
    task automatic predict_leaf(input item_t it, input bit typed, input res_t want);
        longint dx [NI];
        longint diff [NI];
        longint u [NI];
        longint w [NI];
        longint nxt [NI][NI];
        longint q, acc, su, sw, p, c1, c, m, t;
        bit f, own;
        res_t r;
        begin
            f = 1'b0;
            for (int i = 0; i < NI; i++)
            begin
                diff[i] = longint'($signed(it.point[i])) - leaf_center[i];
                dx[i] = narrow(fl(diff[i] * leaf_scale[i]), f);
            end
            case (it.cmd)
                CMD_LOAD:
                begin
                    t = longint'(it.value);
                    if (it.target == TGT_CENTER && it.row < NI)
                        leaf_center[it.row] = t;
                    else if (it.target == TGT_BASE && it.row < NO)
                        leaf_base[it.row] = t;
                    else if (it.target == TGT_GAIN && it.row < NI && it.col < NO)
                        leaf_gain[it.row][it.col] = t;
                    else if (it.target == TGT_ELLIPSOID && it.row < NI && it.col < NI)
                        leaf_ell[it.row][it.col] = t;
                end
                CMD_QUERY:
                begin
                    n_query++;
                    q = 0;
                    for (int i = 0; i < NI; i++)
                        for (int j = 0; j < NI; j++)
                        begin
                            t = narrow(fl(dx[i] * dx[j]), f);
                            q += fl(t * leaf_ell[i][j]);
                        end
                    for (int i = 0; i < NO; i++)
                    begin
                        own = f;
                        acc = leaf_base[i];
                        for (int j = 0; j < NI; j++)
                            acc += fl(diff[j] * leaf_gain[j][i]);
                        acc = narrow(acc, own);
                        r.status = own ? ST_SAT : ST_OK;
                        r.in_region = (q <= ONE);
                        r.index = i[5:0];
                        r.value = acc[31:0];
                        r.last = (i == NO - 1);
                        leaf_results_q.push_back(r);
                    end
                end
                CMD_GROW:
                begin
                    n_grow++;
                    for (int i = 0; i < NI; i++)
                    begin
                        su = 0;
                        sw = 0;
                        for (int j = 0; j < NI; j++)
                        begin
                            su += fl(leaf_ell[i][j] * dx[j]);
                            sw += fl(leaf_ell[j][i] * dx[j]);
                        end
                        u[i] = narrow(su, f);
                        w[i] = narrow(sw, f);
                    end
                    p = 0;
                    for (int i = 0; i < NI; i++)
                        p += fl(dx[i] * u[i]);
                    p = narrow(p, f);
                    r.in_region = 1'b0;
                    r.index = 6'd0;
                    r.value = 32'sd0;
                    r.last = 1'b1;
                    if (p == 0)
                    begin
                        n_degen++;
                        r.status = ST_DEGEN;
                    end
                    else
                    begin
                        c1 = narrow(((ONE - p) * ONE) / p, f);
                        c = narrow((c1 * ONE) / p, f);
                        for (int i = 0; i < NI; i++)
                            for (int j = 0; j < NI; j++)
                            begin
                                m = narrow(fl(u[i] * w[j]), f);
                                nxt[i][j] = narrow(leaf_ell[i][j] + fl(c * m), f);
                            end
                        leaf_ell = nxt;
                        r.status = f ? ST_SAT : ST_OK;
                    end
                    leaf_results_q.push_back(typed ? want : r);
                end
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic send_request(input item_t it, input bit typed, input res_t want);
        begin
            if ($urandom_range(99) < tx_idle)
            begin
                push <= 1'b0;
                repeat ($urandom_range(4, 1)) @(posedge clk);
            end
            push <= 1'b1;
            command <= it.cmd;
            load_target <= it.target;
            load_row <= it.row;
            load_col <= it.col;
            load_value <= it.value;
            point_0 <= it.point[0];
            point_1 <= it.point[1];
            point_2 <= it.point[2];
            point_3 <= it.point[3];
            @(posedge clk);
            while (full)
                @(posedge clk);
            n_items++;
            predict_leaf(it, typed, want);
        end
    endtask

    // a trailing load may still be in flight when the queue drains
    task automatic drain_leaf();
        begin
            push <= 1'b0;
            while (leaf_results_q.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_scale(input logic [2:0] idx, input logic [30:0] data);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            if (idx < NI)
                leaf_scale[idx] = longint'(data);
            @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_point(input int k);
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return leaf_center[k][31:0] + $signed($urandom_range(262144)) - 32'sd131072;
        if (sel < 80)
            return sel[0] ? 32'h7fffffff : 32'h80000000;
        return $urandom;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int sel;
        logic [31:0] v;
        sel = $urandom_range(99);
        it = mk(CMD_QUERY, $urandom_range(3), $urandom_range(63), $urandom_range(63),
                $urandom, rand_point(0), rand_point(1), rand_point(2), rand_point(3));
        if (sel < 35)
            it.cmd = CMD_QUERY;
        else if (sel < 62)
            it.cmd = CMD_GROW;
        else if (sel < 95)
        begin
            it.cmd = CMD_LOAD;
            if ($urandom_range(9) < 8)
            begin
                it.row = $urandom_range(3);
                it.col = $urandom_range(it.target == TGT_GAIN ? 7 : 3);
                if (it.target == TGT_BASE)
                    it.row = $urandom_range(7);
            end
            if (it.target == TGT_ELLIPSOID && $urandom_range(9) < 8)
            begin
                v = $signed($urandom_range(65536)) - 32'sd32768;
                it.value = (it.row == it.col) ? v + 32'sd65536 : v;
            end
            else if ($urandom_range(9) < 7)
                it.value = $signed($urandom_range(1048576)) - 32'sd524288;
        end
        else
            it.cmd = cmd_t'(CMD_RSVD);
        return it;
    endfunction

    task automatic run_random(input int count);
        res_t none;
        begin
            none = '0;
            for (int k = 0; k < count; k++)
                send_request(rand_item(), 1'b0, none);
            drain_leaf();
        end
    endtask

    // result checker and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                n_results++;
                if (status == ST_SAT)
                    n_sat++;
                if (leaf_results_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: index %0d value %0d", out_index,
                                 out_value);
                end
                else if (leaf_results_q[0].status !== status
                         || leaf_results_q[0].in_region !== in_region
                         || leaf_results_q[0].index !== out_index
                         || leaf_results_q[0].value !== out_value
                         || leaf_results_q[0].last !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                 leaf_results_q[0].status, leaf_results_q[0].in_region,
                                 leaf_results_q[0].index, leaf_results_q[0].value,
                                 leaf_results_q[0].last, status, in_region, out_index,
                                 out_value, last);
                end
                if (leaf_results_q.size() != 0)
                    void'(leaf_results_q.pop_front());
            end
            pop <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        res_t none;
        res_t degen;
        none = '0;
        degen = '0;
        degen.status = ST_DEGEN;
        degen.last = 1'b1;
        for (int i = 0; i < NI; i++)
            leaf_scale[i] = ONE;
        tx_idle = 16;
        rx_idle = 87;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every entry before anything reads them; ellipsoid starts at zero
        for (int i = 0; i < NI; i++)
            send_request(mk(CMD_LOAD, TGT_CENTER, i, 0, 32'sd0, 0, 0, 0, 0), 0, none);
        for (int i = 0; i < NO; i++)
            send_request(mk(CMD_LOAD, TGT_BASE, i, 0, i * 65536, 0, 0, 0, 0), 0, none);
        for (int j = 0; j < NI; j++)
            for (int i = 0; i < NO; i++)
                send_request(mk(CMD_LOAD, TGT_GAIN, j, i, (i - j) * 16384, 0, 0, 0, 0),
                             0, none);
        for (int i = 0; i < NI; i++)
            for (int j = 0; j < NI; j++)
                send_request(mk(CMD_LOAD, TGT_ELLIPSOID, i, j, 32'sd0, 0, 0, 0, 0), 0,
                             none);

        // zero ellipsoid, then point at center: both grows are degenerate
        dir_rows.push_back('{mk(CMD_GROW, 0, 0, 0, 0, 32'h00010000, 0, 0, 0), 1, degen});
        dir_rows.push_back('{mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
        for (int i = 0; i < NI; i++)
            dir_rows.push_back('{mk(CMD_LOAD, TGT_ELLIPSOID, i, i, 32'sd65536,
                                    0, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk(CMD_GROW, 0, 0, 0, 0, 0, 0, 0, 0), 1, degen});
        dir_rows.push_back('{mk(CMD_QUERY, 0, 0, 0, 0, 32'h00008000, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk(CMD_GROW, 0, 0, 0, 0, 32'h00018000, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk(CMD_QUERY, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff,
                                32'h7fffffff, 32'h7fffffff), 0, none});
        dir_rows.push_back('{mk(CMD_QUERY, 0, 0, 0, 0, 32'h80000000, 32'h80000000,
                                32'h80000000, 32'h80000000), 0, none});
        dir_rows.push_back('{mk(CMD_GROW, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000,
                                32'h7fffffff, 32'h80000000), 0, none});
        dir_rows.push_back('{mk(CMD_LOAD, TGT_BASE, 0, 0, 32'h7fffffff, 0, 0, 0, 0), 0,
                             none});
        dir_rows.push_back('{mk(CMD_LOAD, TGT_BASE, 7, 0, 32'h80000000, 0, 0, 0, 0), 0,
                             none});
        dir_rows.push_back('{mk(CMD_LOAD, TGT_CENTER, 63, 63, 32'hffffffff, 0, 0, 0, 0),
                             0, none});
        dir_rows.push_back('{mk(CMD_LOAD, TGT_BASE, 8, 0, 32'h12345678, 0, 0, 0, 0), 0,
                             none});
        dir_rows.push_back('{mk(CMD_LOAD, TGT_GAIN, 3, 8, 32'h12345678, 0, 0, 0, 0), 0,
                             none});
        dir_rows.push_back('{mk(CMD_LOAD, TGT_ELLIPSOID, 0, 4, 32'h12345678, 0, 0, 0, 0),
                             0, none});
        dir_rows.push_back('{mk(CMD_RSVD, 3, 63, 63, 32'hffffffff, 32'hffffffff,
                                32'hffffffff, 32'hffffffff, 32'hffffffff), 0, none});
        dir_rows.push_back('{mk(CMD_QUERY, 0, 0, 0, 0, 32'h00010000, 32'hffff0000,
                                32'h00004000, 32'h00000000), 0, none});
        dir_rows.push_back('{mk(CMD_GROW, 0, 0, 0, 0, 32'hffff8000, 32'h00004000,
                                32'h00002000, 32'h00001000), 0, none});
        foreach (dir_rows[k])
            send_request(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);
        drain_leaf();

        run_random(75);

        tx_idle = 87;
        rx_idle = 16;
        write_scale(CFG_SCALE_INV_0, 31'd131072);
        write_scale(CFG_SCALE_INV_1, 31'd32768);
        write_scale(CFG_SCALE_INV_2, 31'd0);
        write_scale(CFG_SCALE_INV_3, 31'h7fffffff);
        write_scale(3'd5, 31'h5555aaaa);
        run_random(75);

        tx_idle = 0;
        rx_idle = 0;
        write_scale(CFG_SCALE_INV_0, 31'h7fffffff);
        write_scale(CFG_SCALE_INV_1, 31'd0);
        write_scale(CFG_SCALE_INV_2, 31'd65536);
        write_scale(CFG_SCALE_INV_3, 31'd1);
        write_scale(3'd7, 31'h2aaa5555);
        run_random(40);
        write_scale(CFG_SCALE_INV_0, 31'd65536);
        write_scale(CFG_SCALE_INV_1, 31'd65536);
        write_scale(CFG_SCALE_INV_2, 31'd49152);
        write_scale(CFG_SCALE_INV_3, 31'd98304);
        run_random(39);

        $display("covered %0d requests: %0d queries, %0d grows (%0d degenerate)",
                 n_items, n_query, n_grow, n_degen);
        $display("checked %0d results, %0d saturated, %0d mismatches", n_results, n_sat,
                 mismatches);
        if (mismatches == 0 && leaf_results_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
